// File: rtl/core/tls_pkg.sv
// Shared widths, category codes and result type for the token lexer stream.
`timescale 1ns / 1ps

package tls_pkg;

  localparam int unsigned LengthBits = 16;
  localparam int unsigned CatBits    = 3;
  localparam int unsigned TokLenBits = 16;
  localparam int unsigned ByteBits   = 8;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrBits = $clog2(QDepth);
  localparam int unsigned QCntBits = $clog2(QDepth + 1);

  localparam logic [CatBits-1:0] CatNone   = CatBits'(0);
  localparam logic [CatBits-1:0] CatIdent  = CatBits'(1);
  localparam logic [CatBits-1:0] CatOper   = CatBits'(2);
  localparam logic [CatBits-1:0] CatString = CatBits'(3);
  localparam logic [CatBits-1:0] CatNumber = CatBits'(4);

  typedef struct packed {
    logic [CatBits-1:0]    category;
    logic [TokLenBits-1:0] token_length;
    logic                  last_of_run;
  } result_t;

endpackage

// File: rtl/core/tls_in_if.sv
// Input channel carrying one text byte per transaction.
`timescale 1ns / 1ps

interface tls_in_if
  import tls_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ByteBits-1:0] char_byte;
  logic                end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

// File: rtl/core/tls_out_if.sv
// Output channel carrying one finished token per transaction.
`timescale 1ns / 1ps

interface tls_out_if
  import tls_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CatBits-1:0]    category;
  logic [TokLenBits-1:0] token_length;
  logic                  last_of_run;

  modport source (output valid, output category, output token_length, output last_of_run,
                  input ready);
  modport sink (input valid, input category, input token_length, input last_of_run,
                output ready);
endinterface

// File: rtl/core/token_lexer_stream_core.sv
// Top level of the byte-serial token lexer with its result queue.
// A token finished by a byte is registered into the result queue and offered from its head.
// Throughput: one byte per cycle while the result queue has room for two results;
// a byte that finishes two tokens writes both into the four-entry result queue.
// Reset: asynchronous, active low; clears the lexer state and empties the result queue.
`timescale 1ns / 1ps

module token_lexer_stream_core
  import tls_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  tls_in_if.sink   in_i,
  tls_out_if.source out_o
);

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeSpace   = 3'd1;
  localparam logic [2:0] ModeIdent   = 3'd2;
  localparam logic [2:0] ModeOpRun   = 3'd3;
  localparam logic [2:0] ModeString  = 3'd4;
  localparam logic [2:0] ModeComment = 3'd5;
  localparam logic [2:0] ModeNumber  = 3'd6;

  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChUnder     = 8'h5f;
  localparam logic [7:0] ChTilde     = 8'h7e;
  localparam logic [7:0] ChDollar    = 8'h24;
  localparam logic [7:0] ChBacktick  = 8'h60;
  localparam logic [7:0] ChLowerE    = 8'h65;
  localparam logic [7:0] ChDot       = 8'h2e;

  localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {[8'h61:8'h7a]}) || (b inside {[8'h41:8'h5a]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_single_op(input logic [7:0] b);
    return b inside {8'h5b, 8'h5d, 8'h28, 8'h29, 8'h7b, 8'h7d, ChTilde};
  endfunction

  function automatic logic is_op_run(input logic [7:0] b);
    return b inside {8'h2c, ChDot, 8'h3a, 8'h3c, 8'h3e, 8'h3d, 8'h2d, 8'h2b, 8'h2a, 8'h2f,
                     8'h25, 8'h26, 8'h7c, 8'h5e, 8'h40, 8'h21, 8'h3f, 8'h3b, ChDollar,
                     ChBacktick};
  endfunction

  function automatic logic continues(input logic [2:0] mode, input logic [7:0] b);
    logic c;
    case (mode)
      ModeSpace:   c = (b == ChSpace);
      ModeIdent:   c = is_alpha(b) || is_digit(b) || (b == ChUnder);
      ModeOpRun:   c = is_op_run(b);
      ModeComment: c = (b != ChNewline);
      ModeNumber:  c = is_digit(b) || (b == ChDot) || (b == ChBacktick) || (b == ChLowerE);
      default:     c = 1'b0;
    endcase
    return c;
  endfunction

  function automatic logic [CatBits-1:0] mode_cat(input logic [2:0] mode);
    logic [CatBits-1:0] c;
    case (mode)
      ModeIdent:  c = CatIdent;
      ModeOpRun:  c = CatOper;
      ModeNumber: c = CatNumber;
      default:    c = CatNone;
    endcase
    return c;
  endfunction

  function automatic logic [LengthBits-1:0] len_inc(input logic [LengthBits-1:0] v);
    return (v == LenMax) ? v : v + LengthBits'(1);
  endfunction

  function automatic logic [TokLenBits-1:0] len_sat(input logic [LengthBits-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (|w[31:TokLenBits]) ? {TokLenBits{1'b1}} : w[TokLenBits-1:0];
  endfunction

  logic [2:0]            mode_q, mode_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic                  esc_q, esc_d;

  result_t               queue_q [QDepth];
  logic [QPtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntBits-1:0]   count_q;

  logic                  in_acc, out_acc;
  logic [1:0]            n_res;
  logic [CatBits-1:0]    res_cat [2];
  logic [LengthBits-1:0] res_len [2];
  logic [7:0]            b;

  assign in_i.ready = (count_q <= QCntBits'(QDepth - 2));
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign b          = in_i.char_byte;

  always_comb begin
    mode_d     = mode_q;
    len_d      = len_q;
    esc_d      = esc_q;
    n_res      = 2'd0;
    res_cat[0] = CatNone;
    res_cat[1] = CatNone;
    res_len[0] = '0;
    res_len[1] = '0;
    if (in_acc) begin
      if (mode_q == ModeString) begin
        len_d = len_inc(len_q);
        if ((b == ChQuote) && !esc_q) begin
          res_cat[0] = CatString;
          res_len[0] = len_d;
          n_res      = 2'd1;
          mode_d     = ModeIdle;
          len_d      = '0;
          esc_d      = 1'b0;
        end else begin
          esc_d = (b == ChBackslash);
        end
      end else if ((mode_q != ModeIdle) && continues(mode_q, b)) begin
        len_d = len_inc(len_q);
      end else begin
        if (mode_q != ModeIdle) begin
          res_cat[0] = mode_cat(mode_q);
          res_len[0] = len_q;
          n_res      = 2'd1;
        end
        esc_d  = 1'b0;
        len_d  = LengthBits'(1);
        mode_d = ModeIdle;
        if (b == ChSpace) begin
          mode_d = ModeSpace;
        end else if (is_alpha(b) || (b == ChUnder)) begin
          mode_d = ModeIdent;
        end else if (is_op_run(b) && !is_single_op(b)) begin
          mode_d = ModeOpRun;
        end else if (b == ChQuote) begin
          mode_d = ModeString;
        end else if (b == ChHash) begin
          mode_d = ModeComment;
        end else if (is_digit(b)) begin
          mode_d = ModeNumber;
        end else begin
          len_d               = '0;
          res_cat[n_res[0]]   = is_single_op(b) ? CatOper : CatNone;
          res_len[n_res[0]]   = LengthBits'(1);
          n_res               = n_res + 2'd1;
        end
      end
      if (in_i.end_of_text && (mode_d != ModeIdle)) begin
        res_cat[n_res[0]] = mode_cat(mode_d);
        res_len[n_res[0]] = len_d;
        n_res             = n_res + 2'd1;
        mode_d            = ModeIdle;
        len_d             = '0;
        esc_d             = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      len_q  <= '0;
      esc_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      len_q  <= len_d;
      esc_q  <= esc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrBits'(n_res);
      rd_ptr_q <= rd_ptr_q + QPtrBits'(out_acc);
      count_q  <= count_q + QCntBits'(n_res) - QCntBits'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= '{category: res_cat[0], token_length: len_sat(res_len[0]),
                             last_of_run: (n_res == 2'd1)};
    end
    if (n_res == 2'd2) begin
      queue_q[wr_ptr_q + QPtrBits'(1)] <= '{category: res_cat[1],
                                            token_length: len_sat(res_len[1]),
                                            last_of_run: 1'b1};
    end
  end

  assign out_o.valid        = (count_q != '0);
  assign out_o.category     = queue_q[rd_ptr_q].category;
  assign out_o.token_length = queue_q[rd_ptr_q].token_length;
  assign out_o.last_of_run  = queue_q[rd_ptr_q].last_of_run;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntBits'(QDepth))
    else $error("result queue overflow");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeIdle) |-> ((len_q == '0) && !esc_q))
    else $error("idle state with open token data");

  a_escape_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (mode_q == ModeString))
    else $error("escape flag outside a string");

  a_eot_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.end_of_text) |=> (mode_q == ModeIdle))
    else $error("open token left after end of text");

  a_nonzero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.token_length != '0))
    else $error("token of zero length offered");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the token lexer: drives byte texts and checks every finished token.
`timescale 1ns / 1ps

module tb_top;
  import tls_pkg::*;

  localparam logic [ByteBits-1:0] ChSpace     = 8'h20;
  localparam logic [ByteBits-1:0] ChQuote     = 8'h27;
  localparam logic [ByteBits-1:0] ChHash      = 8'h23;
  localparam logic [ByteBits-1:0] ChNewline   = 8'h0A;
  localparam logic [ByteBits-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteBits-1:0] ChUnder     = 8'h5F;
  localparam logic [ByteBits-1:0] ChLowE      = 8'h65;
  localparam logic [ByteBits-1:0] ChBacktick  = 8'h60;
  localparam logic [ByteBits-1:0] ChDot       = 8'h2E;

  localparam string AlphaPool  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string IdentPool  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string SinglePool = "[](){}~";
  localparam string OpPool     = ",.:<>=-+*/%&|^@!?;$\140";
  localparam string DigitPool  = "0123456789";
  localparam string NumberPool = "0123456789.\140e";

  typedef enum logic [2:0] {
    ModeIdle,
    ModeSpace,
    ModeIdent,
    ModeOprun,
    ModeString,
    ModeComment,
    ModeNumber
  } lex_mode_e;

  class token_scoreboard;
    result_t               expected_tokens[$];
    int unsigned           mismatches;
    lex_mode_e             mode;
    logic [LengthBits-1:0] run_len;
    logic                  escaped;

    function new();
      mode       = ModeIdle;
      run_len    = '0;
      escaped    = 1'b0;
      mismatches = 0;
    endfunction

    function bit is_alpha(logic [ByteBits-1:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit is_digit(logic [ByteBits-1:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_op_run(logic [ByteBits-1:0] b);
      case (b)
        ",", ".", ":", "<", ">", "=", "-", "+", "*", "/", "%", "&", "|", "^", "@", "!",
        "?", ";", "$", ChBacktick: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function logic [LengthBits-1:0] bump(logic [LengthBits-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function logic [CatBits-1:0] category_of(lex_mode_e m);
      case (m)
        ModeIdent:  return CatIdent;
        ModeOprun:  return CatOper;
        ModeNumber: return CatNumber;
        default:    return CatNone;
      endcase
    endfunction

    function result_t token_of(logic [CatBits-1:0] cat, logic [LengthBits-1:0] len);
      result_t t;
      t.category     = cat;
      t.token_length = (len > {TokLenBits{1'b1}}) ? {TokLenBits{1'b1}} : TokLenBits'(len);
      t.last_of_run  = 1'b0;
      return t;
    endfunction

    task report_mismatch(string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatches++;
    endtask

    function void note_byte(logic [ByteBits-1:0] b, logic eot);
      result_t step_q[$];
      bit      grows;
      bit      single;
      case (mode)
        ModeSpace:   grows = (b == ChSpace);
        ModeIdent:   grows = is_alpha(b) || is_digit(b) || b == ChUnder;
        ModeOprun:   grows = is_op_run(b);
        ModeComment: grows = (b != ChNewline);
        ModeNumber:  grows = is_digit(b) || b == ChDot || b == ChBacktick || b == ChLowE;
        default:     grows = 1'b0;
      endcase
      case (b)
        "[", "]", "(", ")", "{", "}", "~": single = 1'b1;
        default: single = 1'b0;
      endcase
      if (mode == ModeString) begin
        run_len = bump(run_len);
        if (b == ChQuote && !escaped) begin
          step_q  = {step_q, token_of(CatString, run_len)};
          mode    = ModeIdle;
          run_len = '0;
          escaped = 1'b0;
        end else begin
          escaped = (b == ChBackslash);
        end
      end else if (grows) begin
        run_len = bump(run_len);
      end else begin
        if (mode != ModeIdle) step_q = {step_q, token_of(category_of(mode), run_len)};
        mode    = ModeIdle;
        run_len = '0;
        escaped = 1'b0;
        if (b == ChSpace) mode = ModeSpace;
        else if (is_alpha(b) || b == ChUnder) mode = ModeIdent;
        else if (single) step_q = {step_q, token_of(CatOper, LengthBits'(1))};
        else if (is_op_run(b)) mode = ModeOprun;
        else if (b == ChQuote) mode = ModeString;
        else if (b == ChHash) mode = ModeComment;
        else if (is_digit(b)) mode = ModeNumber;
        else step_q = {step_q, token_of(CatNone, LengthBits'(1))};
        if (mode != ModeIdle) run_len = LengthBits'(1);
      end
      if (eot && mode != ModeIdle) begin
        step_q  = {step_q, token_of(category_of(mode), run_len)};
        mode    = ModeIdle;
        run_len = '0;
        escaped = 1'b0;
      end
      if (step_q.size() != 0) step_q[step_q.size() - 1].last_of_run = 1'b1;
      expected_tokens = {expected_tokens, step_q};
    endfunction

    task check_token(result_t got);
      result_t want;
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token category %0d length %0d",
                                  got.category, got.token_length));
        return;
      end
      want = expected_tokens.pop_front();
      if (got.category !== want.category)
        report_mismatch($sformatf("category %0d, predicted %0d", got.category, want.category));
      if (got.token_length !== want.token_length)
        report_mismatch($sformatf("token_length %0d, predicted %0d",
                                  got.token_length, want.token_length));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %0b, predicted %0b",
                                  got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic clk;
  logic rst_n;

  tls_in_if  in_if ();
  tls_out_if out_if ();

  token_lexer_stream_core u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  token_scoreboard       sb = new();
  int unsigned           send_idle_pct  = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           hold_req       = 0;
  logic [ByteBits-1:0]   text_q[$];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin : recv_ready
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_token(result_t'{out_if.category, out_if.token_length, out_if.last_of_run});
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [ByteBits-1:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void put_byte(input logic [ByteBits-1:0] c);
    text_q = {text_q, c};
  endfunction

  function automatic void add_token();
    logic [ByteBits-1:0] c;
    case ($urandom_range(0, 8))
      0: repeat ($urandom_range(1, 4)) put_byte(ChSpace);
      1: begin
        put_byte(pick(AlphaPool));
        repeat ($urandom_range(0, 6)) put_byte(pick(IdentPool));
      end
      2: put_byte(pick(SinglePool));
      3: repeat ($urandom_range(1, 3)) put_byte(pick(OpPool));
      4: begin
        put_byte(ChQuote);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 4))
            0: begin
              put_byte(ChBackslash);
              put_byte(ChQuote);
            end
            1: put_byte(ChBackslash);
            2: put_byte(8'($urandom_range(8'h20, 8'h7E)));
            default: put_byte(pick(IdentPool));
          endcase
        end
        if ($urandom_range(99) < 85) put_byte(ChQuote);
      end
      5: begin
        put_byte(ChHash);
        repeat ($urandom_range(0, 8)) begin
          c = 8'($urandom_range(0, 255));
          put_byte((c == ChNewline) ? ChSpace : c);
        end
        if ($urandom_range(99) < 80) put_byte(ChNewline);
      end
      6: begin
        put_byte(pick(DigitPool));
        repeat ($urandom_range(0, 5)) put_byte(pick(NumberPool));
      end
      7: put_byte(ChNewline);
      default: put_byte(8'($urandom_range(0, 255)));
    endcase
  endfunction

  task automatic send_byte(input logic [ByteBits-1:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.char_byte   <= b;
    in_if.end_of_text <= eot;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_byte(b, eot);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && (i == s.len() - 1));
  endtask

  task automatic flush_text(input bit eot);
    foreach (text_q[i]) send_byte(text_q[i], eot && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  task automatic run_phase(input int unsigned items);
    int unsigned sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
      else
        repeat ($urandom_range(1, 12)) add_token();
      sent += text_q.size();
      flush_text($urandom_range(9) != 0);
    end
  endtask

  initial begin : stimulus
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.char_byte   = '0;
    in_if.end_of_text = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_text("x1(", 1'b0);
    send_text("  3.\140e+", 1'b1);
    send_text("'a\\''", 1'b1);
    send_text("#c\n", 1'b0);
    send_text("'q", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("_", 1'b1);

    // The output stays blocked long enough for the result queue to fill and stall the input.
    hold_req = 300;
    run_phase(420);
    send_idle_pct = 59;
    run_phase(410);
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    run_phase(410);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    run_phase(410);
    in_if.valid <= 1'b0;

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
